FILE: rtl/sapq_pkg.sv
// Shared types and constants for the sorted array priority queue.
`timescale 1ns / 1ps

package sapq_pkg;

  // Fixed port widths
  localparam int ITEM_PORT_W  = 32;
  localparam int PRIO_W       = 16;
  localparam int COUNT_PORT_W = 5;
  localparam int REQ_W        = 2;
  localparam int STATUS_W     = 2;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH  = 2'd0,
    REQ_POP   = 2'd1,
    REQ_INCR  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  // Datapath operations
  typedef enum logic [2:0] {
    OP_NOP,
    OP_PUSH,
    OP_POP,
    OP_INCR,
    OP_CLEAR,
    OP_SORT_EVEN,
    OP_SORT_ODD
  } op_e;

  // Command from controller to datapath
  typedef struct packed {
    op_e op;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
  } dp_stat_t;

endpackage

FILE: rtl/sorted_array_priority_queue.sv
// Top level of the sorted array priority queue.
`timescale 1ns / 1ps

// Priority queue of up to CAPACITY (item, priority) entries kept in descending
// priority order, equal priorities in arrival order. A request transfers at a
// rising edge with start_i high and busy_o low; its one result appears on the
// result ports for exactly one cycle, marked by valid_o, and must be taken
// then, since the receiver cannot stall. For push, pop and clear the result
// shows in the cycle after the transfer, and a new request may transfer in
// that same cycle. Increase updates all matching entries at the transfer and
// then runs CAPACITY odd-even transposition passes over the entry array, one
// per cycle, holding busy_o high; its result shows in the cycle after the last
// pass. head_priority_o and entry_count_o reflect the store after the
// operation.

module sorted_array_priority_queue import sapq_pkg::*; #(
  parameter int CAPACITY   = 16,
  parameter int ITEM_WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [REQ_W-1:0]         req_type_i,
  input  logic [ITEM_PORT_W-1:0]   item_value_i,
  input  logic signed [PRIO_W-1:0] priority_value_i,
  output logic                     valid_o,
  output logic [ITEM_PORT_W-1:0]   popped_item_o,
  output logic [STATUS_W-1:0]      status_o,
  output logic signed [PRIO_W-1:0] head_priority_o,
  output logic [COUNT_PORT_W-1:0]  entry_count_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Controller
  sapq_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_type_i (req_type_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .busy_o     (busy_o),
    .valid_o    (valid_o),
    .status_o   (status_o)
  );

  // Datapath
  sapq_datapath #(
    .CAPACITY   (CAPACITY),
    .ITEM_WIDTH (ITEM_WIDTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .item_value_i     (item_value_i),
    .priority_value_i (priority_value_i),
    .stat_o           (stat),
    .popped_item_o    (popped_item_o),
    .head_priority_o  (head_priority_o),
    .entry_count_o    (entry_count_o)
  );

endmodule

FILE: rtl/sapq_ctrl.sv
// Controller state machine: decodes requests and sequences the sort passes.
`timescale 1ns / 1ps

module sapq_ctrl import sapq_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [REQ_W-1:0]    req_type_i,
  input  dp_stat_t            stat_i,
  output dp_cmd_t             cmd_o,
  output logic                busy_o,
  output logic                valid_o,
  output logic [STATUS_W-1:0] status_o
);

  localparam int PW = $clog2(CAPACITY);

  typedef enum logic {
    ST_IDLE,
    ST_SORT
  } state_e;

  state_e        state_q;
  logic [PW-1:0] pass_q;
  logic          valid_q;
  status_e       status_q;
  logic          accept;
  req_e          req;
  status_e       status_d;

  assign req    = req_e'(req_type_i);
  assign accept = (state_q == ST_IDLE) && start_i;

  // Decode the request into a datapath command
  always_comb begin
    cmd_o.op = OP_NOP;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          case (req)
            REQ_PUSH:  cmd_o.op = OP_PUSH;
            REQ_POP:   cmd_o.op = OP_POP;
            REQ_INCR:  cmd_o.op = OP_INCR;
            REQ_CLEAR: cmd_o.op = OP_CLEAR;
            default:   cmd_o.op = OP_NOP;
          endcase
        end
      end
      ST_SORT: cmd_o.op = pass_q[0] ? OP_SORT_ODD : OP_SORT_EVEN;
      default: cmd_o.op = OP_NOP;
    endcase
  end

  // Work out the status from the store state seen at the transfer
  always_comb begin
    status_d = STAT_OK;
    if ((req == REQ_PUSH) && stat_i.full) begin
      status_d = STAT_FULL;
    end else if ((req == REQ_POP) && stat_i.empty) begin
      status_d = STAT_EMPTY;
    end
  end

  // State, pass counter and registered result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      pass_q   <= '0;
      valid_q  <= 1'b0;
      status_q <= STAT_OK;
    end else begin
      valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            status_q <= status_d;
            if (req == REQ_INCR) begin
              state_q <= ST_SORT;
              pass_q  <= '0;
            end else begin
              valid_q <= 1'b1;
            end
          end
        end
        ST_SORT: begin
          pass_q <= pass_q + 1'b1;
          if (pass_q == PW'(CAPACITY - 1)) begin
            state_q <= ST_IDLE;
            valid_q <= 1'b1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy_o   = (state_q == ST_SORT);
  assign valid_o  = valid_q;
  assign status_o = status_q;

endmodule

FILE: rtl/sapq_datapath.sv
// Datapath: sorted entry array with parallel insert, shift, update and sort passes.
`timescale 1ns / 1ps

module sapq_datapath import sapq_pkg::*; #(
  parameter int CAPACITY   = 16,
  parameter int ITEM_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dp_cmd_t                       cmd_i,
  input  logic [ITEM_PORT_W-1:0]        item_value_i,
  input  logic signed [PRIO_W-1:0]      priority_value_i,
  output dp_stat_t                      stat_o,
  output logic [ITEM_PORT_W-1:0]        popped_item_o,
  output logic signed [PRIO_W-1:0]      head_priority_o,
  output logic [COUNT_PORT_W-1:0]       entry_count_o
);

  localparam int IW = (ITEM_WIDTH < ITEM_PORT_W) ? ITEM_WIDTH : ITEM_PORT_W;
  localparam int CW = $clog2(CAPACITY + 1);

  logic [IW-1:0]            item_q [CAPACITY];
  logic signed [PRIO_W-1:0] prio_q [CAPACITY];
  logic [IW-1:0]            item_d [CAPACITY];
  logic signed [PRIO_W-1:0] prio_d [CAPACITY];
  logic [CW-1:0]            count_q;
  logic [CW-1:0]            count_d;
  logic [IW-1:0]            popped_q;

  // Neighbor views of each cell
  logic [IW-1:0]            item_prev [CAPACITY];
  logic signed [PRIO_W-1:0] prio_prev [CAPACITY];
  logic [IW-1:0]            item_next [CAPACITY];
  logic signed [PRIO_W-1:0] prio_next [CAPACITY];

  logic [CAPACITY-1:0]      live;
  logic [CAPACITY-1:0]      ge;
  logic [CAPACITY-1:0]      ge_prev;
  logic [CAPACITY-1:0]      match;
  logic [CAPACITY-1:0]      swap;
  logic [CAPACITY-1:0]      swap_prev;
  logic signed [PRIO_W-1:0] prio_sat [CAPACITY];
  logic signed [PRIO_W:0]   sum [CAPACITY];

  logic [IW-1:0]            item_in;
  logic                     full;
  logic                     empty;
  logic                     phase;

  assign item_in = item_value_i[IW-1:0];
  assign full    = (count_q == CW'(CAPACITY));
  assign empty   = (count_q == '0);
  assign phase   = (cmd_i.op == OP_SORT_ODD);

  // Per-cell compare, match and saturating add
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      live[i]  = (CW'(i) < count_q);
      ge[i]    = live[i] && (prio_q[i] >= priority_value_i);
      match[i] = live[i] && (item_q[i] == item_in);
      sum[i]   = {prio_q[i][PRIO_W-1], prio_q[i]}
               + {priority_value_i[PRIO_W-1], priority_value_i};
      if (sum[i][PRIO_W] != sum[i][PRIO_W-1]) begin
        prio_sat[i] = sum[i][PRIO_W] ? {1'b1, {(PRIO_W-1){1'b0}}}
                                     : {1'b0, {(PRIO_W-1){1'b1}}};
      end else begin
        prio_sat[i] = sum[i][PRIO_W-1:0];
      end
    end
  end

  // Swap flags of one odd-even transposition pass; pair j covers cells j and j+1
  always_comb begin
    for (int j = 0; j < CAPACITY; j++) begin
      if (j < CAPACITY - 1) begin
        swap[j] = (phase == j[0]) && (CW'(j + 1) < count_q) && (prio_q[j] < prio_next[j]);
      end else begin
        swap[j] = 1'b0;
      end
    end
  end

  // Build neighbor views
  always_comb begin
    item_prev[0] = item_in;
    prio_prev[0] = priority_value_i;
    ge_prev[0]   = 1'b1;
    swap_prev[0] = 1'b0;
    for (int i = 1; i < CAPACITY; i++) begin
      item_prev[i] = item_q[i-1];
      prio_prev[i] = prio_q[i-1];
      ge_prev[i]   = ge[i-1];
      swap_prev[i] = swap[i-1];
    end
    for (int i = 0; i < CAPACITY - 1; i++) begin
      item_next[i] = item_q[i+1];
      prio_next[i] = prio_q[i+1];
    end
    item_next[CAPACITY-1] = item_q[CAPACITY-1];
    prio_next[CAPACITY-1] = prio_q[CAPACITY-1];
  end

  // Next value of every cell and of the fill count
  always_comb begin
    count_d = count_q;
    for (int i = 0; i < CAPACITY; i++) begin
      item_d[i] = item_q[i];
      prio_d[i] = prio_q[i];
    end
    case (cmd_i.op)
      OP_PUSH: begin
        if (!full) begin
          count_d = count_q + 1'b1;
          for (int i = 0; i < CAPACITY; i++) begin
            if (!ge[i]) begin
              if (ge_prev[i]) begin
                item_d[i] = item_in;
                prio_d[i] = priority_value_i;
              end else begin
                item_d[i] = item_prev[i];
                prio_d[i] = prio_prev[i];
              end
            end
          end
        end
      end
      OP_POP: begin
        if (!empty) begin
          count_d = count_q - 1'b1;
          for (int i = 0; i < CAPACITY; i++) begin
            item_d[i] = item_next[i];
            prio_d[i] = prio_next[i];
          end
        end
      end
      OP_INCR: begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (match[i]) begin
            prio_d[i] = prio_sat[i];
          end
        end
      end
      OP_CLEAR: count_d = '0;
      OP_SORT_EVEN, OP_SORT_ODD: begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (swap[i]) begin
            item_d[i] = item_next[i];
            prio_d[i] = prio_next[i];
          end else if (swap_prev[i]) begin
            item_d[i] = item_prev[i];
            prio_d[i] = prio_prev[i];
          end
        end
      end
      default: count_d = count_q;
    endcase
  end

  // Hold the fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Hold entry contents and the popped item
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < CAPACITY; i++) begin
      item_q[i] <= item_d[i];
      prio_q[i] <= prio_d[i];
    end
    case (cmd_i.op)
      OP_PUSH, OP_INCR, OP_CLEAR: popped_q <= '0;
      OP_POP:  popped_q <= empty ? '0 : item_q[0];
      default: popped_q <= popped_q;
    endcase
  end

  assign stat_o.full     = full;
  assign stat_o.empty    = empty;
  assign popped_item_o   = ITEM_PORT_W'(popped_q);
  assign head_priority_o = empty ? '0 : prio_q[0];
  assign entry_count_o   = COUNT_PORT_W'(count_q);

endmodule

FILE: tb/sv/tb_sorted_array_priority_queue.sv
// Self-checking testbench for the sorted array priority queue.
`timescale 1ns / 1ps

module tb_sorted_array_priority_queue;
  import sapq_pkg::*;

  localparam int CAP         = 16;
  localparam int N_RANDOM    = 550;
  localparam int MAX_GAP     = 12;
  localparam int SETTLE_CYC  = CAP + 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PRIO_HI     = 32767;
  localparam int PRIO_LO     = -32768;

  typedef struct {
    req_e                     kind;
    logic [ITEM_PORT_W-1:0]   item;
    logic signed [PRIO_W-1:0] prio;
    int                       gap;
    bit                       drain;
  } request_t;

  typedef struct {
    logic [ITEM_PORT_W-1:0]   popped;
    status_e                  status;
    logic signed [PRIO_W-1:0] head;
    logic [COUNT_PORT_W-1:0]  count;
  } outcome_t;

  logic                     clk            = 1'b0;
  logic                     rst_n          = 1'b0;
  logic                     start          = 1'b0;
  logic [REQ_W-1:0]         req_type       = '0;
  logic [ITEM_PORT_W-1:0]   item_value     = '0;
  logic signed [PRIO_W-1:0] priority_value = '0;
  logic                     busy;
  logic                     valid;
  logic [ITEM_PORT_W-1:0]   popped_item;
  logic [STATUS_W-1:0]      status;
  logic signed [PRIO_W-1:0] head_priority;
  logic [COUNT_PORT_W-1:0]  entry_count;

  // Mirror of the entry store
  logic [ITEM_PORT_W-1:0]   mirror_item [CAP];
  logic signed [PRIO_W-1:0] mirror_prio [CAP];
  int                       mirror_fill = 0;

  request_t req_backlog [$];
  outcome_t due_results [$];
  request_t staged;
  bit       staged_ok  = 1'b0;
  int       wait_left  = 0;
  int       sent_cnt   = 0;
  int       total_reqs = 0;
  int       fault_cnt  = 0;
  int       cycle_cnt  = 0;

  sorted_array_priority_queue #(
    .CAPACITY   (CAP),
    .ITEM_WIDTH (ITEM_PORT_W)
  ) u_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .start_i          (start),
    .busy_o           (busy),
    .req_type_i       (req_type),
    .item_value_i     (item_value),
    .priority_value_i (priority_value),
    .valid_o          (valid),
    .popped_item_o    (popped_item),
    .status_o         (status),
    .head_priority_o  (head_priority),
    .entry_count_o    (entry_count)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Apply one request to the mirror and return the result it should give
  function automatic outcome_t sorted_step(req_e kind, logic [ITEM_PORT_W-1:0] item,
                                           logic signed [PRIO_W-1:0] prio);
    outcome_t                 res;
    int                       pos;
    int                       j;
    int                       sum;
    logic [ITEM_PORT_W-1:0]   it;
    logic signed [PRIO_W-1:0] pr;
    res.popped = '0;
    res.status = STAT_OK;
    case (kind)
      REQ_PUSH: begin
        if (mirror_fill >= CAP) begin
          res.status = STAT_FULL;
        end else begin
          // land after every entry of equal or higher priority
          pos = 0;
          while (pos < mirror_fill && mirror_prio[pos] >= prio) pos++;
          for (j = mirror_fill; j > pos; j--) begin
            mirror_item[j] = mirror_item[j-1];
            mirror_prio[j] = mirror_prio[j-1];
          end
          mirror_item[pos] = item;
          mirror_prio[pos] = prio;
          mirror_fill++;
        end
      end
      REQ_POP: begin
        if (mirror_fill == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          res.popped = mirror_item[0];
          for (j = 0; j + 1 < mirror_fill; j++) begin
            mirror_item[j] = mirror_item[j+1];
            mirror_prio[j] = mirror_prio[j+1];
          end
          mirror_fill--;
        end
      end
      REQ_INCR: begin
        // saturating update of every matching entry
        for (j = 0; j < mirror_fill; j++) begin
          if (mirror_item[j] == item) begin
            sum = int'(mirror_prio[j]) + int'(prio);
            if (sum > PRIO_HI) sum = PRIO_HI;
            if (sum < PRIO_LO) sum = PRIO_LO;
            mirror_prio[j] = sum[PRIO_W-1:0];
          end
        end
        // stable re-sort, descending priority
        for (pos = 1; pos < mirror_fill; pos++) begin
          it = mirror_item[pos];
          pr = mirror_prio[pos];
          j  = pos;
          while (j > 0 && mirror_prio[j-1] < pr) begin
            mirror_item[j] = mirror_item[j-1];
            mirror_prio[j] = mirror_prio[j-1];
            j--;
          end
          mirror_item[j] = it;
          mirror_prio[j] = pr;
        end
      end
      default: mirror_fill = 0;
    endcase
    res.head  = (mirror_fill > 0) ? mirror_prio[0] : '0;
    res.count = mirror_fill[COUNT_PORT_W-1:0];
    return res;
  endfunction

  task automatic add_req(req_e kind, logic [ITEM_PORT_W-1:0] item, int prio, int gap, bit drain);
    request_t r;
    r.kind  = kind;
    r.item  = item;
    r.prio  = prio[PRIO_W-1:0];
    r.gap   = gap;
    r.drain = drain;
    req_backlog.push_back(r);
  endtask

  // Mostly a small pool so increases find matches and duplicates occur
  function automatic logic [ITEM_PORT_W-1:0] draw_item();
    case ($urandom_range(0, 9))
      0, 1:    return 32'd0;
      2, 3:    return 32'd1;
      4:       return 32'd2;
      5:       return 32'h8000_0001;
      6, 7:    return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Mix of clustered, random and extreme priorities
  function automatic int draw_prio();
    int unsigned r;
    int          v;
    r = $urandom_range(0, 9);
    if (r < 4)       v = int'($urandom_range(0, 6)) - 3;
    else if (r < 8)  v = $urandom;
    else if (r == 8) v = PRIO_HI;
    else             v = PRIO_LO;
    return v;
  endfunction

  // Driver: present queued requests, honoring per-item gaps and drain pauses
  always @(posedge clk) begin : drive_proc
    logic go;
    go = start;
    if (rst_n) begin
      if (start && !busy) begin
        due_results.push_back(sorted_step(req_e'(req_type), item_value, priority_value));
        sent_cnt++;
        go = 1'b0;
      end
      if (!go) begin
        if (!staged_ok && req_backlog.size() > 0) begin
          staged    = req_backlog.pop_front();
          staged_ok = 1'b1;
          wait_left = staged.gap;
        end
        if (staged_ok) begin
          if (wait_left > 0) begin
            wait_left--;
          end else if (!staged.drain || due_results.size() == 0) begin
            req_type       <= staged.kind;
            item_value     <= staged.item;
            priority_value <= staged.prio;
            go        = 1'b1;
            staged_ok = 1'b0;
          end
        end
      end
    end
    start <= go;
  end

  // Monitor: compare each result transfer with the oldest expectation
  always @(posedge clk) begin : check_proc
    outcome_t want;
    if (rst_n && valid) begin
      if (due_results.size() == 0) begin
        $error("unexpected result: popped_item %h status %0d head_priority %0d entry_count %0d",
               popped_item, status, head_priority, entry_count);
        fault_cnt++;
      end else begin
        want = due_results.pop_front();
        if (popped_item !== want.popped) begin
          $error("popped_item: expected %h, got %h", want.popped, popped_item);
          fault_cnt++;
        end
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          fault_cnt++;
        end
        if (head_priority !== want.head) begin
          $error("head_priority: expected %0d, got %0d", want.head, head_priority);
          fault_cnt++;
        end
        if (entry_count !== want.count) begin
          $error("entry_count: expected %0d, got %0d", want.count, entry_count);
          fault_cnt++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("** sorted_array_priority_queue: FAILED **");
      $finish;
    end
  end

  initial begin : main_proc
    int   mode;
    int   gap_hi;
    int   roll;
    int   push_lim;
    int   pop_lim;
    int   delta;
    req_e kind;
    bit   drain;

    // Directed: empty-store cases, extremes, ties, saturation, reorder, full, clear
    add_req(REQ_POP,  32'd0,          0,       0, 1'b0);
    add_req(REQ_INCR, 32'd1,          5,       1, 1'b0);
    add_req(REQ_PUSH, 32'd0,          PRIO_LO, 0, 1'b0);
    add_req(REQ_PUSH, 32'hFFFF_FFFF,  PRIO_HI, 2, 1'b0);
    add_req(REQ_PUSH, 32'd5,          0,       0, 1'b0);
    add_req(REQ_PUSH, 32'd6,          0,       0, 1'b0);
    add_req(REQ_INCR, 32'd5,          0,       0, 1'b0);
    add_req(REQ_INCR, 32'h1234_5678,  100,     3, 1'b0);
    add_req(REQ_INCR, 32'hFFFF_FFFF,  PRIO_HI, 0, 1'b0);
    add_req(REQ_INCR, 32'd0,          PRIO_LO, 0, 1'b0);
    add_req(REQ_INCR, 32'd6,          1,       0, 1'b0);
    add_req(REQ_POP,  32'd0,          0,       1, 1'b0);
    for (int k = 0; k < 13; k++) begin
      add_req(REQ_PUSH, 32'd7 + (k % 3), (k % 4) * 10 - 15, k % 2, 1'b0);
    end
    add_req(REQ_PUSH, 32'hA5A5_5A5A,  PRIO_HI, 0, 1'b0);
    add_req(REQ_INCR, 32'd8,          -40,     0, 1'b0);
    add_req(REQ_CLEAR, 32'd0,         0,       0, 1'b0);
    add_req(REQ_POP,  32'd0,          0,       0, 1'b0);

    // Random: chunks that lean toward filling, draining or balance
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 40 == 0) begin
        mode   = $urandom_range(0, 2);
        gap_hi = ($urandom_range(0, 2) == 0) ? 0 : MAX_GAP;
      end
      case (mode)
        0:       begin push_lim = 70; pop_lim = 82; end
        1:       begin push_lim = 30; pop_lim = 80; end
        default: begin push_lim = 50; pop_lim = 80; end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < 2)             kind = REQ_CLEAR;
      else if (roll < push_lim) kind = REQ_PUSH;
      else if (roll < pop_lim)  kind = REQ_POP;
      else                      kind = REQ_INCR;
      delta = ($urandom_range(0, 9) == 0) ? 0 : draw_prio();
      drain = (n == N_RANDOM / 2) || ($urandom_range(0, 99) == 0);
      add_req(kind, draw_item(), (kind == REQ_INCR) ? delta : draw_prio(),
              $urandom_range(0, gap_hi), drain);
    end
    total_reqs = req_backlog.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Hold until every request is sent and answered, then let stray results surface
    while (sent_cnt < total_reqs || due_results.size() > 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);

    if (fault_cnt == 0) begin
      $display("** sorted_array_priority_queue: PASSED **");
    end else begin
      $display("** sorted_array_priority_queue: FAILED **");
    end
    $finish;
  end

endmodule
